// ===== hw/rtl/lsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsm_pkg: shared types and constants of the line substring matcher
// Register indexes, payload widths, the configuration view handed to the
// match core, the result word and the ascii case fold.
// ----------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

   localparam int unsigned PATTERN_BYTES    = 32;
   localparam int unsigned PATTERN_LEN_BITS = 6;
   localparam int unsigned CSR_INDEX_BITS   = 3;
   localparam int unsigned CSR_DATA_BITS    = 64;
   localparam int unsigned LINE_INDEX_BITS  = 32;
   localparam int unsigned KEPT_LENGTH_BITS = 9;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] UPPER_A_CHAR = 8'h41;
   localparam logic [7:0] UPPER_Z_CHAR = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PATTERN_A  = 3'd0,
      REG_PATTERN_B  = 3'd1,
      REG_PATTERN_C  = 3'd2,
      REG_PATTERN_D  = 3'd3,
      REG_PATTERN_LEN = 3'd4,
      REG_FOLD_CASE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [PATTERN_BYTES-1:0][7:0] pattern;   // already case folded
      logic [PATTERN_LEN_BITS-1:0]   used_len;  // clipped to the vector size
      logic                          fold_case;
   } cfg_type;

   typedef struct packed {
      logic                        line_matched;
      logic [LINE_INDEX_BITS-1:0]  line_index;
      logic [KEPT_LENGTH_BITS-1:0] kept_length;
   } rsp_word_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c, input logic enable);
      logic [7:0] r;
      r = c;
      if (enable && (c >= UPPER_A_CHAR) && (c <= UPPER_Z_CHAR)) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lsm_if.sv =====
// ----------------------------------------------------------------------------
// lsm_if: channel interfaces of the line substring matcher
// Byte words in, line result words out, and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface lsm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                line_matched;
   logic [lsm_pkg::LINE_INDEX_BITS-1:0]  line_index;
   logic [lsm_pkg::KEPT_LENGTH_BITS-1:0] kept_length;

   modport source (output valid, output line_matched, output line_index,
                   output kept_length, input ready);
   modport sink   (input valid, input line_matched, input line_index,
                   input kept_length, output ready);
endinterface

interface lsm_csr_if;
   logic                               valid;
   logic                               ready;
   logic [lsm_pkg::CSR_INDEX_BITS-1:0] reg_index;
   logic [lsm_pkg::CSR_DATA_BITS-1:0]  write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lsm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lsm_cfg_regs: configuration registers
// Holds pattern, length and fold flag; presents the folded pattern and the
// clipped length to the match core.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_cfg_regs #(
   parameter int unsigned MAX_PATTERN = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  wr_en,
   input  wire [lsm_pkg::CSR_INDEX_BITS-1:0]    wr_index,
   input  wire [lsm_pkg::CSR_DATA_BITS-1:0]     wr_data,
   output lsm_pkg::cfg_type                     cfg
);

   logic [3:0][lsm_pkg::CSR_DATA_BITS-1:0]   pattern_ff;
   logic [lsm_pkg::PATTERN_LEN_BITS-1:0]     length_ff;
   logic                                     fold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
         fold_ff    <= 1'b0;
      end else if (wr_en) begin
         unique case (wr_index)
            lsm_pkg::REG_PATTERN_A:   pattern_ff[0] <= wr_data;
            lsm_pkg::REG_PATTERN_B:   pattern_ff[1] <= wr_data;
            lsm_pkg::REG_PATTERN_C:   pattern_ff[2] <= wr_data;
            lsm_pkg::REG_PATTERN_D:   pattern_ff[3] <= wr_data;
            lsm_pkg::REG_PATTERN_LEN: length_ff <= wr_data[lsm_pkg::PATTERN_LEN_BITS-1:0];
            lsm_pkg::REG_FOLD_CASE:   fold_ff <= wr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int b = 0; b < lsm_pkg::PATTERN_BYTES; b++) begin
         cfg.pattern[b] = lsm_pkg::fold_char(pattern_ff[b/8][(b%8)*8 +: 8], fold_ff);
      end
      // lengths beyond the match vector are clipped
      if ({1'b0, length_ff} > 7'(MAX_PATTERN)) begin
         cfg.used_len = lsm_pkg::PATTERN_LEN_BITS'(MAX_PATTERN);
      end else begin
         cfg.used_len = length_ff;
      end
      cfg.fold_case = fold_ff;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lsm_match_core.sv =====
// ----------------------------------------------------------------------------
// lsm_match_core: per-line shift-and matcher
// Keeps the line state and updates it once per byte; flags a result word
// at a newline or at the end of a nonempty unterminated last line.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_match_core #(
   parameter int unsigned MAX_PATTERN      = 32,
   parameter int unsigned LINE_STORE       = 512,
   parameter int unsigned LINE_NUMBER_BITS = 32
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     step,
   input  wire [7:0]               data_byte,
   input  wire                     end_of_file,
   input  lsm_pkg::cfg_type        cfg,
   output logic                    emit,
   output lsm_pkg::rsp_word_type   result
);

   localparam int unsigned KEPT_W = $clog2(LINE_STORE);
   localparam logic [KEPT_W-1:0] KEPT_MAX = KEPT_W'(LINE_STORE - 1);
   localparam logic [LINE_NUMBER_BITS-1:0] LINE_MAX = {LINE_NUMBER_BITS{1'b1}};
   localparam logic [LINE_NUMBER_BITS-1:0] LINE_FIRST = LINE_NUMBER_BITS'(1);

   logic [MAX_PATTERN-1:0]       vec_ff, vec_in;
   logic                         found_ff, found_in;
   logic [KEPT_W-1:0]            kept_ff, kept_in;
   logic [LINE_NUMBER_BITS-1:0]  line_ff, line_in;

   logic [7:0]             fc;
   logic                   is_nl;
   logic                   keep;
   logic [MAX_PATTERN-1:0] eq;
   logic [MAX_PATTERN-1:0] tap;
   logic [MAX_PATTERN-1:0] vec_next;
   logic                   found_k;
   logic [KEPT_W-1:0]      kept_k;
   logic [KEPT_W+lsm_pkg::KEPT_LENGTH_BITS-1:0]          kept_wide;
   logic [LINE_NUMBER_BITS+lsm_pkg::LINE_INDEX_BITS-1:0] line_wide;

   assign fc    = lsm_pkg::fold_char(data_byte, cfg.fold_case);
   assign is_nl = (data_byte == lsm_pkg::NEWLINE_CHAR);
   assign keep  = !is_nl && (kept_ff < KEPT_MAX);

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
      logic [7:0] pbyte;
      if (k < lsm_pkg::PATTERN_BYTES) begin : g_stored
         assign pbyte = cfg.pattern[k];
      end else begin : g_zero
         assign pbyte = 8'h00;
      end
      assign eq[k]  = ({1'b0, cfg.used_len} > 7'(k)) && (pbyte == fc);
      assign tap[k] = ({1'b0, cfg.used_len} == 7'(k + 1));
   end

   assign vec_next = ((vec_ff << 1) | MAX_PATTERN'(1)) & eq;
   assign found_k  = found_ff || (keep && |(vec_next & tap));
   assign kept_k   = kept_ff + KEPT_W'(keep);

   assign kept_wide = {{lsm_pkg::KEPT_LENGTH_BITS{1'b0}}, kept_k};
   assign line_wide = {{lsm_pkg::LINE_INDEX_BITS{1'b0}}, line_ff};

   always_comb begin
      emit = is_nl || (end_of_file && (kept_k != '0));
      // empty pattern: any nonempty line matches
      result.line_matched = (cfg.used_len == '0) ? (kept_k != '0) : found_k;
      result.line_index   = line_wide[lsm_pkg::LINE_INDEX_BITS-1:0];
      result.kept_length  = kept_wide[lsm_pkg::KEPT_LENGTH_BITS-1:0];

      vec_in   = keep ? vec_next : vec_ff;
      found_in = found_k;
      kept_in  = kept_k;
      line_in  = line_ff;
      if (is_nl || end_of_file) begin
         vec_in   = '0;
         found_in = 1'b0;
         kept_in  = '0;
      end
      if (end_of_file) begin
         line_in = LINE_FIRST;
      end else if (is_nl && (line_ff != LINE_MAX)) begin
         line_in = line_ff + LINE_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff   <= '0;
         found_ff <= 1'b0;
         kept_ff  <= '0;
         line_ff  <= LINE_FIRST;
      end else if (step) begin
         vec_ff   <= vec_in;
         found_ff <= found_in;
         kept_ff  <= kept_in;
         line_ff  <= line_in;
      end
   end

`ifndef SYNTHESIS
   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      step && end_of_file |=> (line_ff == LINE_FIRST) && (kept_ff == '0) && !found_ff)
      else $error("end of file did not restart line state");

   a_kept_clips: assert property (@(posedge clock) disable iff (reset)
      step && !is_nl && !end_of_file && (kept_ff == KEPT_MAX) |=> kept_ff == KEPT_MAX)
      else $error("kept count moved past the line store limit");

   a_line_never_zero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line counter wrapped to zero");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/line_substring_matcher.sv =====
// ----------------------------------------------------------------------------
// line_substring_matcher: fixed-string grep over a byte stream
// Splits the stream into lines and reports per line whether the pattern
// occurs, with the line number and the number of bytes kept.
// ----------------------------------------------------------------------------
// Throughput is one byte word per clock sustained while the result slot is
// free or drained. One result word is given for every finished line: at a
// newline byte, or at a byte flagged end_of_file that leaves a nonempty
// unterminated line. An accepted byte waits in the input register; its result
// word then goes to the result register. The shift-and vector, found flag and
// kept count are updated once per byte, and an end_of_file byte restarts line
// numbering at 1. Pattern and options go through the csr channel (always
// ready); the user must write them only while the block is idle, which the
// block does not enforce. The pattern is up to 32 bytes; A-Z folding is optional.
`default_nettype none

module line_substring_matcher #(
   parameter int unsigned MAX_PATTERN      = 32,
   parameter int unsigned LINE_STORE       = 512,
   parameter int unsigned LINE_NUMBER_BITS = 32
) (
   input  wire           clock,
   input  wire           reset,
   lsm_req_if.sink       req_bus,
   lsm_rsp_if.source     rsp_bus,
   lsm_csr_if.sink       csr_bus
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;

   // result register
   logic                  rsp_valid_ff;
   lsm_pkg::rsp_word_type rsp_word_ff;

   lsm_pkg::cfg_type      cfg;
   lsm_pkg::rsp_word_type result;
   logic                  emit;
   logic                  advance;

   // the held byte moves on when the result slot is free or being drained
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   lsm_cfg_regs #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid),
      .wr_index (csr_bus.reg_index),
      .wr_data  (csr_bus.write_data),
      .cfg      (cfg)
   );

   lsm_match_core #(
      .MAX_PATTERN      (MAX_PATTERN),
      .LINE_STORE       (LINE_STORE),
      .LINE_NUMBER_BITS (LINE_NUMBER_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .end_of_file (in_eof_ff),
      .cfg         (cfg),
      .emit        (emit),
      .result      (result)
   );

   // input stage: capture a word whenever the stage is empty or moving on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
         in_eof_ff  <= req_bus.end_of_file;
      end
   end

   // result stage: a byte that ends no line still frees the slot if drained
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.line_matched = rsp_word_ff.line_matched;
   assign rsp_bus.line_index   = rsp_word_ff.line_index;
   assign rsp_bus.kept_length  = rsp_word_ff.kept_length;

`ifndef SYNTHESIS
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> in_valid_ff)
      else $error("accepted word not held in the input stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_eof_ff))
      else $error("stalled input word changed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff && $stable(rsp_word_ff))
      else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/line_substring_matcher_tb.sv =====
// ----------------------------------------------------------------------------
// line_substring_matcher_tb: self-checking bench for the line substring matcher
// Streams byte words through the block under random idling on both channels,
// predicts every line result from a behavioral copy of the match state and
// compares each result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module line_substring_matcher_tb;

   localparam int unsigned KEEP_LIMIT   = 511;      // bytes kept per line
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 8;        // covers the input and result stages
   localparam int unsigned IDLE_PCT     = 16;
   localparam logic [7:0]  LOWER_A_CHAR = 8'h61;
   localparam logic [7:0]  LOWER_Z_CHAR = 8'h7A;

   typedef logic [7:0] pattern_bytes_type [lsm_pkg::PATTERN_BYTES];

   logic clock = 1'b0;
   logic reset;

   lsm_req_if req_bus ();
   lsm_rsp_if rsp_bus ();
   lsm_csr_if csr_bus ();

   line_substring_matcher uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // behavioral copy of the matcher: registers and per-line state
   // ---------------------------------------------------------------------------
   logic [63:0]  pat_reg [4];
   logic [5:0]   pat_len_reg;
   logic         fold_reg;
   logic [31:0]  shift_vec;       // bit k set: pattern bytes 0..k end at the last byte
   bit           found_hit;
   int unsigned  kept_bytes;
   logic [31:0]  line_seq;

   lsm_pkg::rsp_word_type line_result_q [$];   // predicted result words, oldest first

   int unsigned  fail_count    = 0;
   int unsigned  cycle_count   = 0;
   int unsigned  hold_off_left = 0;   // receiver stall requested by a test
   bit           steady_flow   = 1'b0; // no idling on either side while set

   function automatic logic [7:0] fold_byte(input logic [7:0] c);
      if (fold_reg && c >= lsm_pkg::UPPER_A_CHAR && c <= lsm_pkg::UPPER_Z_CHAR)
         return c + lsm_pkg::CASE_OFFSET;
      return c;
   endfunction

   function automatic logic [7:0] pattern_at(input int unsigned k);
      return pat_reg[k / 8][(k % 8) * 8 +: 8];
   endfunction

   // lengths above the vector size count as a full-length pattern
   function automatic int unsigned active_len();
      return (pat_len_reg > lsm_pkg::PATTERN_BYTES) ? lsm_pkg::PATTERN_BYTES : pat_len_reg;
   endfunction

   function automatic void clear_line_state();
      shift_vec  = '0;
      found_hit  = 1'b0;
      kept_bytes = 0;
   endfunction

   function automatic void take_byte(input logic [7:0] c);
      logic [31:0]  eq;
      int unsigned  len;
      logic [7:0]   fc;
      len = active_len();
      fc  = fold_byte(c);
      eq  = '0;
      // bytes past the line store are dropped silently
      if (kept_bytes >= KEEP_LIMIT) return;
      kept_bytes++;
      for (int unsigned k = 0; k < len; k++) begin
         if (fold_byte(pattern_at(k)) == fc) eq[k] = 1'b1;
      end
      shift_vec = {shift_vec[30:0], 1'b1} & eq;
      if (len > 0 && shift_vec[len - 1]) found_hit = 1'b1;
   endfunction

   function automatic void push_line_result();
      lsm_pkg::rsp_word_type r;
      // empty pattern: any line with kept bytes counts as a hit
      r.line_matched = (active_len() == 0) ? (kept_bytes > 0) : found_hit;
      r.line_index   = line_seq;
      r.kept_length  = kept_bytes[lsm_pkg::KEPT_LENGTH_BITS-1:0];
      line_result_q.push_back(r);
   endfunction

   function automatic void predict_word(input logic [7:0] c, input bit eof);
      if (c == lsm_pkg::NEWLINE_CHAR) begin
         push_line_result();
         if (line_seq != '1) line_seq++;
         clear_line_state();
      end else begin
         take_byte(c);
         // an unterminated last line is closed by the end-of-file flag
         if (eof && kept_bytes > 0) push_line_result();
      end
      if (eof) begin
         clear_line_state();
         line_seq = 1;
      end
   endfunction

   function automatic void apply_reg(input lsm_pkg::csr_index_type idx,
                                     input logic [63:0] data);
      case (idx)
         lsm_pkg::REG_PATTERN_A:   pat_reg[0]  = data;
         lsm_pkg::REG_PATTERN_B:   pat_reg[1]  = data;
         lsm_pkg::REG_PATTERN_C:   pat_reg[2]  = data;
         lsm_pkg::REG_PATTERN_D:   pat_reg[3]  = data;
         lsm_pkg::REG_PATTERN_LEN: pat_len_reg = data[lsm_pkg::PATTERN_LEN_BITS-1:0];
         lsm_pkg::REG_FOLD_CASE:   fold_reg    = data[0];
         default: ;
      endcase
   endfunction

   function automatic pattern_bytes_type pattern_of(input string s);
      pattern_bytes_type p;
      foreach (p[k]) p[k] = (k < s.len()) ? s[k] : 8'h00;
      return p;
   endfunction

   function automatic logic [63:0] pack_lane(input pattern_bytes_type p,
                                             input int unsigned lane);
      logic [63:0] w;
      for (int unsigned j = 0; j < 8; j++) w[j * 8 +: 8] = p[lane * 8 + j];
      return w;
   endfunction

   // ---------------------------------------------------------------------------
   // channel drivers
   // ---------------------------------------------------------------------------

   // one byte word; valid stays high after acceptance so back-to-back words
   // need only one assignment per step
   task automatic send_word(input logic [7:0] b, input bit eof);
      if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.end_of_file <= eof;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_word(b, eof);
   endtask

   task automatic send_text(input string s, input bit eof_on_last);
      for (int i = 0; i < s.len(); i++) send_word(s[i], eof_on_last && (i == s.len() - 1));
   endtask

   // drop valid, wait for every predicted word, then let the pipe empty
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (line_result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input lsm_pkg::csr_index_type idx, input logic [63:0] data);
      csr_bus.valid      <= 1'b1;
      csr_bus.reg_index  <= idx;
      csr_bus.write_data <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      apply_reg(idx, data);
   endtask

   // full register set, only ever written with the block idle
   task automatic load_pattern(input pattern_bytes_type p, input int unsigned len,
                               input bit fold);
      settle_block();
      write_reg(lsm_pkg::REG_PATTERN_A, pack_lane(p, 0));
      write_reg(lsm_pkg::REG_PATTERN_B, pack_lane(p, 1));
      write_reg(lsm_pkg::REG_PATTERN_C, pack_lane(p, 2));
      write_reg(lsm_pkg::REG_PATTERN_D, pack_lane(p, 3));
      write_reg(lsm_pkg::REG_PATTERN_LEN, 64'(len));
      write_reg(lsm_pkg::REG_FOLD_CASE, 64'(fold));
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // receiver: random stalls, long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // result checker: every accepted word against the oldest prediction
   always @(posedge clock) begin
      lsm_pkg::rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (line_result_q.size() == 0) begin
            $error("unexpected result word: line_index %0d", rsp_bus.line_index);
            fail_count++;
         end else begin
            want = line_result_q.pop_front();
            if (rsp_bus.line_matched !== want.line_matched) begin
               $error("line_matched: expected %0d, got %0d",
                      want.line_matched, rsp_bus.line_matched);
               fail_count++;
            end
            if (rsp_bus.line_index !== want.line_index) begin
               $error("line_index: expected %0d, got %0d",
                      want.line_index, rsp_bus.line_index);
               fail_count++;
            end
            if (rsp_bus.kept_length !== want.kept_length) begin
               $error("kept_length: expected %0d, got %0d",
                      want.kept_length, rsp_bus.kept_length);
               fail_count++;
            end
         end
      end
   end

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL line_substring_matcher");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // reset registers give an empty pattern: nonempty lines hit, empty ones do not
   task automatic test_empty_pattern();
      send_text("\n", 1'b0);
      send_word(8'h00, 1'b0);             // zero and all-ones bytes are plain data
      send_word(8'hFF, 1'b0);
      send_word(lsm_pkg::NEWLINE_CHAR, 1'b0);
      send_word("z", 1'b1);               // unterminated last line closed by eof
      send_word(lsm_pkg::NEWLINE_CHAR, 1'b1); // newline with eof, numbering restarted
   endtask

   // folding applies to data and pattern alike, and only when enabled
   task automatic test_fold_case();
      load_pattern(pattern_of("aB"), 2, 1'b1);
      send_text("xAb\n", 1'b0);
      send_text("ab\n", 1'b0);
      load_pattern(pattern_of("aB"), 2, 1'b0);
      send_text("xab\n", 1'b0);
      send_text("aB\n", 1'b0);
      send_text("aB", 1'b1);              // hit completed on the eof word
   endtask

   // full-width pattern spread over all four lanes, length register above the vector size
   task automatic test_pattern_limits();
      pattern_bytes_type p;
      logic [7:0] c;
      foreach (p[k]) p[k] = (k == 0) ? 8'h00 : (k == lsm_pkg::PATTERN_BYTES - 1) ? 8'hFF
                                     : lsm_pkg::UPPER_A_CHAR + 8'(k - 1);
      load_pattern(p, 63, 1'b1);
      // whole pattern, letters sent in lower case
      for (int k = 0; k < lsm_pkg::PATTERN_BYTES; k++) begin
         c = p[k];
         if (c >= lsm_pkg::UPPER_A_CHAR && c <= lsm_pkg::UPPER_Z_CHAR)
            c = c + lsm_pkg::CASE_OFFSET;
         send_word(c, 1'b0);
      end
      send_word(lsm_pkg::NEWLINE_CHAR, 1'b0);
      // last pattern byte missing: no hit
      for (int k = 0; k < lsm_pkg::PATTERN_BYTES - 1; k++) send_word(p[k], 1'b0);
      send_word(lsm_pkg::NEWLINE_CHAR, 1'b0);
   endtask

   // lines past the store: only the first 511 bytes take part
   task automatic test_long_line();
      load_pattern(pattern_of("needle"), 6, 1'b0);
      repeat (505) send_word("x", 1'b0);
      send_text("needle\n", 1'b0);        // pattern ends on the last kept byte
      repeat (506) send_word("x", 1'b0);
      send_text("needlezz", 1'b1);        // pattern cut by the limit, eof past the limit
   endtask

   function automatic logic [7:0] random_symbol();
      int unsigned pick;
      string       syms;
      syms = "aAbB";
      pick = $urandom_range(0, 99);
      if (pick < 60) return syms[$urandom_range(0, 3)];
      if (pick < 85) return lsm_pkg::UPPER_A_CHAR + 8'($urandom_range(0, 25)) +
                            ($urandom_range(0, 1) ? lsm_pkg::CASE_OFFSET : 8'h00);
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic random_config();
      pattern_bytes_type p;
      int unsigned       pick;
      int unsigned       len;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       len = 0;
         1:       len = lsm_pkg::PATTERN_BYTES;
         2:       len = $urandom_range(lsm_pkg::PATTERN_BYTES + 1, 63);
         3, 4:    len = $urandom_range(9, lsm_pkg::PATTERN_BYTES - 1);
         default: len = $urandom_range(1, 8);
      endcase
      foreach (p[k]) p[k] = random_symbol();
      if (pick == 1 && $urandom_range(0, 1)) foreach (p[k]) p[k] = 8'hFF;
      load_pattern(p, len, 1'($urandom_range(0, 1)));
   endtask

   // mostly well-formed lines with the pattern planted at random, some noise lines
   task automatic send_random_line(output int unsigned sent);
      int unsigned len;
      int unsigned shape;
      int unsigned ins_at;
      int unsigned plen;
      int unsigned ending;
      bit          noise;
      bit          plant;
      logic [7:0]  b;
      shape  = $urandom_range(0, 99);
      len    = (shape < 70) ? $urandom_range(0, 20)
             : (shape < 97) ? $urandom_range(21, 80) : $urandom_range(500, 530);
      noise  = ($urandom_range(0, 99) < 10);
      plant  = !noise && ($urandom_range(0, 99) < 45);
      plen   = active_len();
      ins_at = $urandom_range(0, len);
      if (plant && ins_at + plen > len) len = ins_at + plen;
      ending = $urandom_range(0, 99);
      sent   = 0;
      for (int unsigned i = 0; i < len; i++) begin
         if (plant && i >= ins_at && i < ins_at + plen) begin
            b = pattern_at(i - ins_at);
            // flip the case of planted letters when folding is on
            if (fold_reg && (b | lsm_pkg::CASE_OFFSET) >= LOWER_A_CHAR &&
                (b | lsm_pkg::CASE_OFFSET) <= LOWER_Z_CHAR && $urandom_range(0, 1))
               b = b ^ lsm_pkg::CASE_OFFSET;
         end else if (noise) begin
            b = 8'($urandom_range(0, 255));
         end else begin
            do b = random_symbol(); while (b == lsm_pkg::NEWLINE_CHAR);
         end
         // eof on the last data byte of an unterminated line
         send_word(b, (ending >= 95) && (i == len - 1));
         sent++;
      end
      if (ending < 95 || len == 0) begin
         send_word(lsm_pkg::NEWLINE_CHAR, ending >= 90);
         sent++;
      end
   endtask

   task automatic test_random_lines();
      int unsigned sent;
      int unsigned n;
      for (int phase = 0; phase < 10; phase++) begin
         random_config();
         steady_flow = (phase == 4);      // one phase with no idling at all
         sent = 0;
         while (sent < 60) begin
            send_random_line(n);
            sent += n;
         end
      end
      steady_flow = 1'b0;
   endtask

   // receiver holds off while short lines keep coming, so the input must stall
   task automatic test_backpressure();
      load_pattern(pattern_of("x"), 1, 1'b0);
      hold_off_left = 400;
      repeat (60) send_text("x\n", 1'b0);
      settle_block();                     // sender waits for every result word
      repeat (20) send_text("yx\n", 1'b0);
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = 8'h00;
      req_bus.end_of_file = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.reg_index   = lsm_pkg::REG_PATTERN_A;
      csr_bus.write_data  = '0;
      foreach (pat_reg[i]) pat_reg[i] = '0;
      pat_len_reg = '0;
      fold_reg    = 1'b0;
      line_seq    = 1;
      clear_line_state();
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_pattern();
      test_fold_case();
      test_pattern_limits();
      test_long_line();
      test_random_lines();
      test_backpressure();

      settle_block();
      if (fail_count == 0) begin
         $display("PASS line_substring_matcher");
      end else begin
         $display("FAIL line_substring_matcher");
      end
      $finish;
   end

endmodule

`default_nettype wire
